/* src/tsf_pkg.sv */
package tsf_pkg;

   // sample width kept inside the filter (low bits of each converted sample)
   localparam int SAMPLE_BITS = 10;
   // fixed widths of the port fields
   localparam int FIELD_BITS  = 10;
   localparam int LIMIT_BITS  = 10;
   localparam int CMP_BITS    = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;
   localparam int SET_SIZE    = 4;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(10);

   // report kinds
   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_RELEASE  = 2'd1;
   localparam logic [1:0] KIND_POSITION = 2'd2;

   // panel modes
   localparam logic [1:0] MODE_WAIT_DOWN = 2'd0;
   localparam logic [1:0] MODE_MEASURE   = 2'd1;
   localparam logic [1:0] MODE_WAIT_UP   = 2'd2;

   // event function codes
   localparam logic FUNC_EVENT      = 1'b0;
   localparam logic FUNC_CONVERSION = 1'b1;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   // classified command passed from front to back
   typedef enum logic [1:0] {
      OP_RELEASE = 2'd0,
      OP_MEASURE = 2'd1,
      OP_FILTER  = 2'd2
   } op_type;

   typedef struct packed {
      op_type                        op;
      logic [SET_SIZE-1:0][SAMPLE_BITS-1:0] x_set;
      logic [SET_SIZE-1:0][SAMPLE_BITS-1:0] y_set;
   } cmd_word_type;

   // input word
   typedef struct packed {
      logic                  func;
      logic                  pen_up;
      logic [FIELD_BITS-1:0] x_sample;
      logic [FIELD_BITS-1:0] y_sample;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [1:0]            report_kind;
      logic [FIELD_BITS-1:0] x_position;
      logic [FIELD_BITS-1:0] y_position;
      logic [1:0]            next_mode;
      logic                  start_timer;
   } rsp_word_type;

endpackage

/* src/tsf_front.sv */
module tsf_front import tsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  req_word_type req_word,
   input  logic         queue_full,
   output logic         cmd_push,
   output cmd_word_type cmd_word
);

   logic [1:0]  count_ff, count_in;
   sample_type  x_store_ff [SET_SIZE-1];
   sample_type  y_store_ff [SET_SIZE-1];
   sample_type  x_in_smp, y_in_smp;
   logic        accept;

   assign accept   = push & ~queue_full;
   assign cmd_push = accept;
   assign x_in_smp = SAMPLE_BITS'(req_word.x_sample);
   assign y_in_smp = SAMPLE_BITS'(req_word.y_sample);

   // classify the word and track the sample count
   always_comb begin
      count_in          = count_ff;
      cmd_word.op       = OP_MEASURE;
      cmd_word.x_set[0] = x_store_ff[0];
      cmd_word.x_set[1] = x_store_ff[1];
      cmd_word.x_set[2] = x_store_ff[2];
      cmd_word.x_set[3] = x_in_smp;
      cmd_word.y_set[0] = y_store_ff[0];
      cmd_word.y_set[1] = y_store_ff[1];
      cmd_word.y_set[2] = y_store_ff[2];
      cmd_word.y_set[3] = y_in_smp;
      priority if (req_word.pen_up) begin
         cmd_word.op = OP_RELEASE;
         if (req_word.func == FUNC_CONVERSION) begin
            count_in = 2'd0;
         end
      end else if (req_word.func == FUNC_EVENT) begin
         cmd_word.op = OP_MEASURE;
      end else if (count_ff == 2'(SET_SIZE - 1)) begin
         cmd_word.op = OP_FILTER;
         count_in    = 2'd0;
      end else begin
         cmd_word.op = OP_MEASURE;
         count_in    = count_ff + 2'd1;
      end
   end

   // sample count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // sample store, first three samples of a set
   always_ff @(posedge clock) begin
      for (int i = 0; i < SET_SIZE - 1; i++) begin
         if (accept && !req_word.pen_up && req_word.func == FUNC_CONVERSION
             && count_ff == 2'(i)) begin
            x_store_ff[i] <= x_in_smp;
            y_store_ff[i] <= y_in_smp;
         end
      end
   end

endmodule

/* src/tsf_cmd_queue.sv */
module tsf_cmd_queue import tsf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_push,
   input  cmd_word_type  cmd_in_word,
   output logic          full,
   input  logic          cmd_pop,
   output logic          cmd_valid,
   output cmd_word_type  cmd_out_word
);

   cmd_word_type entry_ff [2];
   logic [1:0]   count_ff, count_in;
   logic         wr_ptr_ff, rd_ptr_ff;
   logic         do_push, do_pop;

   assign full         = (count_ff == 2'd2);
   assign cmd_valid    = (count_ff != 2'd0);
   assign cmd_out_word = entry_ff[rd_ptr_ff];
   assign do_push      = cmd_push & ~full;
   assign do_pop       = cmd_pop & cmd_valid;

   always_comb begin
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in_word;
      end
   end

endmodule

/* src/tsf_back.sv */
module tsf_back import tsf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [LIMIT_BITS-1:0] deviation_limit,
   input  logic                  cmd_valid,
   input  cmd_word_type          cmd_word,
   output logic                  cmd_pop,
   output logic                  empty,
   input  logic                  pop,
   output rsp_word_type          rsp_word
);

   rsp_word_type entry_ff [2];
   rsp_word_type result;
   logic [1:0]   count_ff, count_in;
   logic         wr_ptr_ff, rd_ptr_ff;
   logic         res_full, do_pop;
   logic         steady;
   logic [SAMPLE_BITS+1:0] x_sum, y_sum;

   // samples 2 and 3 within limit of the pair before them
   function automatic logic set_is_steady(
      input logic [SET_SIZE-1:0][SAMPLE_BITS-1:0] s,
      input logic [LIMIT_BITS-1:0]                lim
   );
      logic [SAMPLE_BITS:0]   sum01, sum12;
      logic [SAMPLE_BITS-1:0] avg01, avg12, d2, d3;
      sum01 = {1'b0, s[0]} + {1'b0, s[1]};
      sum12 = {1'b0, s[1]} + {1'b0, s[2]};
      avg01 = sum01[SAMPLE_BITS:1];
      avg12 = sum12[SAMPLE_BITS:1];
      d2 = (s[2] > avg01) ? (s[2] - avg01) : (avg01 - s[2]);
      d3 = (s[3] > avg12) ? (s[3] - avg12) : (avg12 - s[3]);
      return (CMP_BITS'(d2) <= CMP_BITS'(lim)) && (CMP_BITS'(d3) <= CMP_BITS'(lim));
   endfunction

   assign res_full = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign cmd_pop  = cmd_valid & ~res_full;
   assign do_pop   = pop & ~empty;
   assign rsp_word = entry_ff[rd_ptr_ff];

   // four-sample sums and the steadiness check
   always_comb begin
      x_sum = '0;
      y_sum = '0;
      for (int i = 0; i < SET_SIZE; i++) begin
         x_sum = x_sum + (SAMPLE_BITS+2)'(cmd_word.x_set[i]);
         y_sum = y_sum + (SAMPLE_BITS+2)'(cmd_word.y_set[i]);
      end
      steady = set_is_steady(cmd_word.x_set, deviation_limit)
               & set_is_steady(cmd_word.y_set, deviation_limit);
   end

   // result word for the command at the queue head
   always_comb begin
      result.report_kind = KIND_NONE;
      result.x_position  = '0;
      result.y_position  = '0;
      result.next_mode   = MODE_MEASURE;
      result.start_timer = 1'b0;
      unique case (cmd_word.op)
         OP_RELEASE: begin
            result.report_kind = KIND_RELEASE;
            result.next_mode   = MODE_WAIT_DOWN;
         end
         OP_MEASURE: begin
            result.next_mode = MODE_MEASURE;
         end
         OP_FILTER: begin
            if (steady) begin
               result.report_kind = KIND_POSITION;
               result.x_position  = FIELD_BITS'(x_sum[SAMPLE_BITS+1:2]);
               result.y_position  = FIELD_BITS'(y_sum[SAMPLE_BITS+1:2]);
            end
            result.next_mode   = MODE_WAIT_UP;
            result.start_timer = 1'b1;
         end
         default: begin
            result.next_mode = MODE_MEASURE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff + {1'b0, cmd_pop} - {1'b0, do_pop};
   end

   // result queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd_pop) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         entry_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

/* src/touchscreen_sample_filter.sv */
// channel   | direction | handshake           | word
// ----------+-----------+---------------------+--------------------------------
// request   | in        | push / full         | req_word (func, pen_up, x, y)
// response  | out       | empty / pop         | rsp_word (kind, x, y, mode, timer)
// csr       | in        | csr_valid/csr_ready | csr_data (deviation limit)
//
// One word per cycle sustained while results are popped. An accepted word is
// held in the command queue, filtered from its head and written to the
// result queue for popping; the two queues each add one stage.
// Synchronous reset clears counts and queues and loads the default limit.
// Command and result queues each hold two entries, so either side can stall
// alone; full rises when the command queue holds two entries.
module touchscreen_sample_filter import tsf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_word_type          req_word,
   output logic                  empty,
   input  logic                  pop,
   output rsp_word_type          rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LIMIT_BITS-1:0] csr_data
);

   logic [LIMIT_BITS-1:0] limit_ff;
   logic                  front_push, cmd_full;
   cmd_word_type          front_word, head_word;
   logic                  cmd_valid, cmd_pop;

   assign csr_ready = 1'b1;
   assign full      = cmd_full;

   // deviation limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   tsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_word   (req_word),
      .queue_full (cmd_full),
      .cmd_push   (front_push),
      .cmd_word   (front_word)
   );

   tsf_cmd_queue u_cmd_queue (
      .clock        (clock),
      .reset        (reset),
      .cmd_push     (front_push),
      .cmd_in_word  (front_word),
      .full         (cmd_full),
      .cmd_pop      (cmd_pop),
      .cmd_valid    (cmd_valid),
      .cmd_out_word (head_word)
   );

   tsf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .deviation_limit (limit_ff),
      .cmd_valid       (cmd_valid),
      .cmd_word        (head_word),
      .cmd_pop         (cmd_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_word        (rsp_word)
   );

endmodule
